// File: design/arm64_address_reference_tracker_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the address reference tracker
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ARM64_ADDRESS_REFERENCE_TRACKER_TOP_ASSERT_SVH
`define ARM64_ADDRESS_REFERENCE_TRACKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define AART_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("aart: implication check failed");
`define AART_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("aart: next-cycle check failed");
`else
`define AART_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define AART_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: design/aart_pkg.sv
// ----------------------------------------------------------------------------
// aart_pkg
// Types and constants shared by the address reference tracker modules.
// ----------------------------------------------------------------------------
package aart_pkg;

  localparam int unsigned NumRegs    = 32;
  localparam int unsigned RegIdxW    = 5;
  localparam int unsigned AddrW      = 64;
  localparam int unsigned CountW     = 7;
  localparam int unsigned QueueDepth = 2;

  // instruction class masks and match patterns
  localparam logic [31:0] MaskPage   = 32'h9f00_0000;
  localparam logic [31:0] PatAdrp    = 32'h9000_0000;
  localparam logic [31:0] PatAdr     = 32'h1000_0000;
  localparam logic [31:0] MaskTop    = 32'hff00_0000;
  localparam logic [31:0] PatAddImm  = 32'h9100_0000;
  localparam logic [31:0] PatLdrLit  = 32'h5800_0000;
  localparam logic [31:0] MaskLdrUo  = 32'hf9c0_0000;
  localparam logic [31:0] PatLdrUo   = 32'hf940_0000;

  // configuration register indexes
  localparam logic CfgTarget  = 1'b0;
  localparam logic CfgMaxRefs = 1'b1;

  localparam logic [6:0] MaxRefsReset = 7'd64;

  // final scan status codes
  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusNone    = 2'd1;
  localparam logic [1:0] StatusTooMany = 2'd2;

  typedef enum logic [2:0] {
    OpNone,   // no effect on tracked state
    OpPage,   // absolute value, never matched
    OpAbs,    // absolute value, matched
    OpAdd,    // source plus addend, unknown source clears dest
    OpLdr     // source plus addend, unknown source leaves state
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [RegIdxW-1:0]   rd;
    logic [RegIdxW-1:0]   rn;
    logic [AddrW-1:0]     addend;
    logic [31:0]          offset;
    logic                 last;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
  } q_ctrl_t;

  typedef struct packed {
    logic   full;
    logic   empty;
  } q_stat_t;

endpackage

// File: design/aart_if.sv
// ----------------------------------------------------------------------------
// aart_in_if / aart_out_if
// Valid/ready channels for instruction words and scan results.
// ----------------------------------------------------------------------------
interface aart_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;
  logic        last;

  modport source (output valid, output instr_word, output last, input ready);
  modport sink   (input valid, input instr_word, input last, output ready);
endinterface

interface aart_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] hit_offset;
  logic        done_res;
  logic [1:0]  scan_status;
  logic [6:0]  ref_count;

  modport source (output valid, output hit, output hit_offset, output done_res,
                  output scan_status, output ref_count, input ready);
  modport sink   (input valid, input hit, input hit_offset, input done_res,
                  input scan_status, input ref_count, output ready);
endinterface

// File: design/aart_front.sv
// ----------------------------------------------------------------------------
// aart_front
// Accepts instruction words, tracks the byte offset and classifies each word
// into an operation with a precomputed 64-bit addend.
// ----------------------------------------------------------------------------
module aart_front #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  aart_in_if.sink              in_i,
  input  aart_pkg::q_stat_t    q_stat_i,
  output logic                 push_o,
  output aart_pkg::entry_t     entry_o
);

  logic [OFFSET_BITS-1:0]      off_q, off_d;
  logic [aart_pkg::AddrW-1:0]  off64;
  logic [31:0]                 w;
  logic [20:0]                 imm21;
  logic [aart_pkg::AddrW-1:0]  imm21_sx;
  logic [aart_pkg::AddrW-1:0]  lit_sx;
  logic [aart_pkg::AddrW-1:0]  imm12;
  logic                        accept;

  assign w        = in_i.instr_word;
  assign in_i.ready = !q_stat_i.full;
  assign accept   = in_i.valid && !q_stat_i.full;
  assign push_o   = accept;

  assign off64    = aart_pkg::AddrW'(off_q);
  assign imm21    = {w[23:5], w[30:29]};
  assign imm21_sx = {{43{imm21[20]}}, imm21};
  assign lit_sx   = {{43{w[23]}}, w[23:5], 2'b00};
  assign imm12    = {52'd0, w[21:10]};

  always_comb begin
    entry_o        = '0;
    entry_o.rd     = w[4:0];
    entry_o.rn     = w[9:5];
    entry_o.offset = 32'(off64);
    entry_o.last   = in_i.last;
    entry_o.op     = aart_pkg::OpNone;
    if ((w & aart_pkg::MaskPage) == aart_pkg::PatAdrp) begin
      entry_o.op     = aart_pkg::OpPage;
      entry_o.addend = (imm21_sx << 12) + (off64 & ~64'hfff);
    end else if ((w & aart_pkg::MaskTop) == aart_pkg::PatAddImm) begin
      // shift codes 2 and 3 are reserved: leave state alone
      if (w[23:22] == 2'd0) begin
        entry_o.op     = aart_pkg::OpAdd;
        entry_o.addend = imm12;
      end else if (w[23:22] == 2'd1) begin
        entry_o.op     = aart_pkg::OpAdd;
        entry_o.addend = imm12 << 12;
      end
    end else if ((w & aart_pkg::MaskLdrUo) == aart_pkg::PatLdrUo) begin
      if (w[21:10] != 12'd0) begin
        entry_o.op     = aart_pkg::OpLdr;
        entry_o.addend = imm12 << 3;
      end
    end else if ((w & aart_pkg::MaskPage) == aart_pkg::PatAdr) begin
      entry_o.op     = aart_pkg::OpAbs;
      entry_o.addend = imm21_sx + off64;
    end else if ((w & aart_pkg::MaskTop) == aart_pkg::PatLdrLit) begin
      entry_o.op     = aart_pkg::OpAbs;
      entry_o.addend = lit_sx + off64;
    end
  end

  // restart the offset after the last word of an image
  assign off_d = in_i.last ? '0 : off_q + OFFSET_BITS'(4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
    end else if (accept) begin
      off_q <= off_d;
    end
  end

endmodule

// File: design/aart_queue.sv
// ----------------------------------------------------------------------------
// aart_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
module aart_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  aart_pkg::q_ctrl_t    ctrl_i,
  input  aart_pkg::entry_t     wdata_i,
  output aart_pkg::entry_t     rdata_o,
  output aart_pkg::q_stat_t    stat_o
);

  localparam int unsigned PtrW = (aart_pkg::QueueDepth > 1) ?
                                 $clog2(aart_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(aart_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(aart_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(aart_pkg::QueueDepth);

  aart_pkg::entry_t        mem_q [aart_pkg::QueueDepth];
  logic [PtrW-1:0]         wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    do_push, do_pop;

  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = ctrl_i.push && !stat_o.full;
  assign do_pop       = ctrl_i.pop && !stat_o.empty;
  assign rdata_o      = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: design/aart_back.sv
// ----------------------------------------------------------------------------
// aart_back
// Holds the tracked register file, applies one classified word per cycle while
// results are taken, matches derived addresses to the target, registers the result.
// ----------------------------------------------------------------------------
`include "arm64_address_reference_tracker_top_assert.svh"

module aart_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [aart_pkg::AddrW-1:0]   target_i,
  input  logic [aart_pkg::CountW-1:0]  max_refs_i,
  input  aart_pkg::entry_t             entry_i,
  input  aart_pkg::q_stat_t            q_stat_i,
  output logic                         pop_o,
  aart_out_if.source                   out_o
);

  logic [aart_pkg::AddrW-1:0]    val_q [aart_pkg::NumRegs];
  logic [aart_pkg::NumRegs-1:0]  known_q, known_d;
  logic [aart_pkg::CountW-1:0]   total_q, total_d;
  logic                          ovf_q, ovf_d;

  logic                          out_valid_q;
  logic                          out_hit_q;
  logic [31:0]                   out_off_q;
  logic                          out_done_q;
  logic [1:0]                    out_status_q;
  logic [aart_pkg::CountW-1:0]   out_count_q;

  logic                          fire;
  logic [aart_pkg::AddrW-1:0]    src_val, new_val;
  logic                          src_known;
  logic                          wr_en, derived, clr_rd, hit;
  logic [1:0]                    status;

  assign fire      = !q_stat_i.empty && (!out_valid_q || out_o.ready);
  assign pop_o     = fire;
  assign src_val   = val_q[entry_i.rn];
  assign src_known = known_q[entry_i.rn];

  always_comb begin
    wr_en   = 1'b0;
    derived = 1'b0;
    clr_rd  = 1'b0;
    new_val = entry_i.addend;
    unique case (entry_i.op) inside
      aart_pkg::OpPage: begin
        wr_en = 1'b1;
      end
      aart_pkg::OpAbs: begin
        wr_en   = 1'b1;
        derived = 1'b1;
      end
      aart_pkg::OpAdd, aart_pkg::OpLdr: begin
        new_val = src_val + entry_i.addend;
        if (src_known) begin
          wr_en   = 1'b1;
          derived = 1'b1;
        end else if (entry_i.op == aart_pkg::OpAdd) begin
          clr_rd = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    hit     = 1'b0;
    total_d = total_q;
    ovf_d   = ovf_q;
    if (derived && (new_val == target_i) && !ovf_q) begin
      if (total_q >= max_refs_i) begin
        ovf_d = 1'b1;
      end else begin
        total_d = total_q + aart_pkg::CountW'(1);
        hit     = 1'b1;
      end
    end
    if (ovf_d) begin
      status = aart_pkg::StatusTooMany;
    end else if (total_d == '0) begin
      status = aart_pkg::StatusNone;
    end else begin
      status = aart_pkg::StatusOk;
    end
  end

  always_comb begin
    known_d = known_q;
    if (wr_en) begin
      known_d[entry_i.rd] = 1'b1;
    end else if (clr_rd) begin
      known_d[entry_i.rd] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_q     <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        // drop all scan state after the last word
        if (entry_i.last) begin
          known_q <= '0;
          total_q <= '0;
          ovf_q   <= 1'b0;
        end else begin
          known_q <= known_d;
          total_q <= total_d;
          ovf_q   <= ovf_d;
        end
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && wr_en) begin
      val_q[entry_i.rd] <= new_val;
    end
    if (fire) begin
      out_hit_q    <= hit;
      out_off_q    <= entry_i.offset;
      out_done_q   <= entry_i.last;
      out_status_q <= entry_i.last ? status : aart_pkg::StatusOk;
      out_count_q  <= total_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.hit         = out_hit_q;
  assign out_o.hit_offset  = out_off_q;
  assign out_o.done_res    = out_done_q;
  assign out_o.scan_status = out_status_q;
  assign out_o.ref_count   = out_count_q;

  `AART_ASSERT_NEXT(a_hit_counts, clk_i, rst_ni, fire && hit && !entry_i.last, total_q == $past(total_q) + aart_pkg::CountW'(1))
  `AART_ASSERT_NEXT(a_ovf_sticky, clk_i, rst_ni, ovf_q && !(fire && entry_i.last), ovf_q)
  `AART_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, fire && entry_i.last, known_q == '0 && total_q == '0 && !ovf_q)
  `AART_ASSERT_IMP(a_hit_counted, clk_i, rst_ni, out_valid_q && out_hit_q, out_count_q != '0)

endmodule

// File: design/arm64_address_reference_tracker_top.sv
// ----------------------------------------------------------------------------
// arm64_address_reference_tracker_top
// Scans a stream of ARM64 instruction words and reports references to a
// configured target address.
// ----------------------------------------------------------------------------
// Takes one instruction word per cycle and gives one result per word, with
// no bubbles as long as the result side keeps taking beats. A word accepted
// by the front is written into the front queue; the back then reads it from
// the queue head, reads the tracked register file, does one 64-bit add and
// compare and registers the result in its output registers, from which the
// result beat is taken. That back stage sets the sustained rate of one word
// per cycle. Write the configuration registers only while no scan beats are
// in flight.
// ----------------------------------------------------------------------------
module arm64_address_reference_tracker_top #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  aart_in_if.sink                      in_i,
  aart_out_if.source                   out_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [aart_pkg::AddrW-1:0]   cfg_data_i
);

  logic [aart_pkg::AddrW-1:0]   target_q;
  logic [aart_pkg::CountW-1:0]  max_refs_q;

  aart_pkg::entry_t   push_entry, head_entry;
  aart_pkg::q_ctrl_t  q_ctrl;
  aart_pkg::q_stat_t  q_stat;
  logic               push, pop;

  assign q_ctrl.push = push;
  assign q_ctrl.pop  = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= '0;
      max_refs_q <= aart_pkg::MaxRefsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        aart_pkg::CfgTarget:  target_q   <= cfg_data_i;
        aart_pkg::CfgMaxRefs: max_refs_q <= cfg_data_i[aart_pkg::CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  aart_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  aart_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (q_ctrl),
    .wdata_i (push_entry),
    .rdata_o (head_entry),
    .stat_o  (q_stat)
  );

  aart_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .target_i   (target_q),
    .max_refs_i (max_refs_q),
    .entry_i    (head_entry),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule
